>>> rtl/core/cggg_pkg.sv
`timescale 1ns / 1ps
// Package for the correlated Gaussian grain generator.
// Holds sizes, generator constants, register codes and sequencer states.
// Depends on nothing.
package cggg_pkg;

   // Line store sizing; the depth is a power of two so the column wraps by masking.
   localparam int LINE_WIDTH = 4096;
   localparam int LS_AW      = $clog2(LINE_WIDTH);

   // Port widths.
   localparam int COLUMN_W    = 12;
   localparam int NOISE_W     = 16;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 64;

   // Generator and logarithm constants.
   localparam logic [31:0] LCG_MUL     = 32'd1664525;
   localparam logic [31:0] LCG_ADD     = 32'd1013904223;
   localparam logic [32:0] TWO_LN2_Q32 = 33'd5954088944;

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SEED    = 3'd0,
      CSR_LUMA    = 3'd1,
      CSR_CHROMA  = 3'd2,
      CSR_HCORR   = 3'd3,
      CSR_VCORR   = 3'd4,
      CSR_SCALE   = 3'd5
   } csr_index_type;

   // Sequencer states.
   typedef enum logic [4:0] {
      ST_IDLE,
      ST_SAMPLE,
      ST_SQRT,
      ST_NSTART,
      ST_LCG_A,
      ST_LCG_B,
      ST_SQ1,
      ST_SQ2,
      ST_CHECK,
      ST_NORM,
      ST_LOG,
      ST_LMUL,
      ST_LSQRT,
      ST_DMUL,
      ST_DLOAD,
      ST_DIV,
      ST_SCALE,
      ST_ROUND,
      ST_DISPATCH,
      ST_HB1,
      ST_HB2,
      ST_HB3,
      ST_VB1,
      ST_VB2,
      ST_VB3,
      ST_OUT
   } state_type;

   // What the plane sample in progress is used for.
   typedef enum logic [1:0] {
      JOB_PRIME,
      JOB_ROW,
      JOB_CUR
   } job_type;

   // Which value the shared square root unit is producing.
   typedef enum logic [1:0] {
      SQ_SD,
      SQ_S,
      SQ_Q
   } sqrt_sel_type;

endpackage

>>> rtl/core/cggg_req_if.sv
`timescale 1ns / 1ps
// Request channel of the grain generator: valid, ready and one work item.
// Depends on cggg_pkg for field widths.
interface cggg_req_if import cggg_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                mode;
   logic [COLUMN_W-1:0] column;
   logic                row_start;
   logic                chroma;

   modport source (output valid, mode, column, row_start, chroma, input ready);
   modport sink   (input valid, mode, column, row_start, chroma, output ready);
endinterface

>>> rtl/core/cggg_rsp_if.sv
`timescale 1ns / 1ps
// Response channel of the grain generator: valid, ready and one noise value.
// Depends on cggg_pkg for the noise width.
interface cggg_rsp_if import cggg_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [NOISE_W-1:0] noise_value;

   modport source (output valid, noise_value, input ready);
   modport sink   (input valid, noise_value, output ready);
endinterface

>>> rtl/core/correlated_gaussian_grain_generator.sv
`timescale 1ns / 1ps
// Film-grain noise generator: LCG, polar Gaussian method, correlation filters.
// Depends on cggg_pkg, cggg_req_if and cggg_rsp_if.
//
//   Port      | Direction | Carries
//   ----------+-----------+------------------------------------------------
//   req_if    | in        | mode, column, row_start, chroma per transaction
//   rsp_if    | out       | noise_value, one transaction per sample item
//   csr_*     | in        | register write: enable, index, 64-bit data
//
// One item is worked at a time. A zero-variance prime skips the generator; a
// sample either uses the cached spare or draws a new pair, and each rejected
// pair is drawn again; a row start adds one more plane sample.
// Most of the time goes into the one-bit-per-cycle square root and divider.
// Reset is synchronous; the line store needs no clearing pass.
// A result waiting on rsp_if does not stop the next item from being taken.
module correlated_gaussian_grain_generator
   import cggg_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   cggg_req_if.sink               req_if,
   cggg_rsp_if.source             rsp_if,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   // Control and configuration registers.
   state_type    state_ff, state_in;
   job_type      job_ff, job_in;
   sqrt_sel_type sqsel_ff, sqsel_in;
   logic         draw_second_ff, draw_second_in;
   logic         div_second_ff, div_second_in;
   logic [4:0]   cnt_ff, cnt_in;
   logic         spare_valid_ff, spare_valid_in;
   logic         out_valid_ff, out_valid_in;
   logic [63:0]  rng_ff, rng_in;
   logic [15:0]  luma_var_ff, luma_var_in;
   logic [15:0]  chroma_var_ff, chroma_var_in;
   logic [16:0]  hcorr_ff, hcorr_in;
   logic [16:0]  vcorr_ff, vcorr_in;
   logic [3:0]   shift_ff, shift_in;
   logic signed [24:0] spare_ff, spare_in;
   logic signed [31:0] prev_ff, prev_in;

   // Datapath registers.
   logic [LS_AW-1:0]   col_ff, col_in;
   logic               chroma_ff, chroma_in;
   logic [53:0]        lcg_lo_ff, lcg_lo_in;
   logic signed [23:0] v1_ff, v1_in;
   logic signed [23:0] v2_ff, v2_in;
   logic [45:0]        r_ff, r_in;
   logic [43:0]        norm_ff, norm_in;
   logic [5:0]         e_ff, e_in;
   logic [30:0]        y_ff, y_in;
   logic [15:0]        frac_ff, frac_in;
   logic [54:0]        lprod_ff, lprod_in;
   logic [63:0]        sq_x_ff, sq_x_in;
   logic [34:0]        sq_rem_ff, sq_rem_in;
   logic [31:0]        sq_root_ff, sq_root_in;
   logic [15:0]        sd_ff, sd_in;
   logic [19:0]        s_ff, s_in;
   logic [31:0]        q_ff, q_in;
   logic [42:0]        dprod_ff, dprod_in;
   logic [31:0]        div_rem_ff, div_rem_in;
   logic [23:0]        div_q_ff, div_q_in;
   logic signed [24:0] z_ff, z_in;
   logic signed [41:0] sprod_ff, sprod_in;
   logic signed [31:0] sample_ff, sample_in;
   logic signed [31:0] cur_ff, cur_in;
   logic signed [50:0] acc_ff, acc_in;
   logic signed [31:0] vres_ff, vres_in;
   logic signed [NOISE_W-1:0] out_noise_ff, out_noise_in;

   // Line store.
   logic signed [31:0] ls_mem [LINE_WIDTH];
   logic signed [31:0] ls_rd_ff;
   logic               mem_we;
   logic               mem_re;
   logic signed [31:0] mem_wd;
   logic               out_load;

   // Combinational helpers.
   logic [15:0]        var_sel;
   logic [53:0]        lcg_lo_next;
   logic [31:0]        lcg_hi_prod;
   logic [63:0]        rng_step;
   logic signed [23:0] v_step;
   logic signed [47:0] v1_sq;
   logic signed [47:0] v2_sq;
   logic [61:0]        y_sq;
   logic [31:0]        ysh;
   logic [21:0]        nl2;
   logic [54:0]        lprod_next;
   logic [22:0]        l_val;
   logic [36:0]        sq_rem_n;
   logic [36:0]        sq_trial;
   logic               sq_ge;
   logic [34:0]        sq_rem_next;
   logic [31:0]        sq_root_next;
   logic signed [23:0] v_cur;
   logic [23:0]        v_abs;
   logic [42:0]        dprod_next;
   logic [53:0]        dividend;
   logic [32:0]        div_rem_n;
   logic               div_ge;
   logic [31:0]        div_rem_next;
   logic [23:0]        div_q_next;
   logic signed [24:0] z_next;
   logic signed [41:0] sprod_next;
   logic signed [31:0] sample_next;
   logic               blend_h;
   logic [16:0]        wh;
   logic [16:0]        wv;
   logic [16:0]        bl_w;
   logic [16:0]        bl_wc;
   logic signed [31:0] bl_a;
   logic signed [49:0] prod_a;
   logic signed [49:0] prod_b;
   logic signed [31:0] blend_round;
   logic [3:0]         sh_eff;
   logic signed [16:0] out_round;
   logic signed [24:0] out_shifted;
   logic signed [24:0] sat_lo;
   logic signed [24:0] sat_hi;
   logic signed [NOISE_W-1:0] noise_next;

   // Round a signed value to a right shift, halves away from zero.
   function automatic logic signed [50:0] rnd_shift(input logic signed [50:0] x,
                                                    input int unsigned n);
      logic [50:0] mag;
      logic [50:0] res;
      mag = x[50] ? 51'(-x) : 51'(x);
      res = (mag + (51'd1 << (n - 1))) >> n;
      return x[50] ? -$signed(res) : $signed(res);
   endfunction

   // Plane variance and LCG step, split into a low half (ST_LCG_A) and a high half (ST_LCG_B).
   assign var_sel     = chroma_ff ? chroma_var_ff : luma_var_ff;
   assign lcg_lo_next = {22'd0, rng_ff[31:0]} * {22'd0, LCG_MUL} + {22'd0, LCG_ADD};
   assign lcg_hi_prod = rng_ff[63:32] * LCG_MUL;
   assign rng_step    = {lcg_hi_prod + {10'd0, lcg_lo_ff[53:32]}, lcg_lo_ff[31:0]};
   assign v_step      = $signed({1'b0, rng_step[22:0]}) - 24'sd4194304;

   // Squared radius of the drawn pair.
   assign v1_sq = v1_ff * v1_ff;
   assign v2_sq = v2_ff * v2_ff;

   // One squaring step of the binary logarithm.
   assign y_sq = {31'd0, y_ff} * {31'd0, y_ff};
   assign ysh  = y_sq[61:30];

   // Negative log2 and its conversion to -2 ln r.
   assign nl2        = {6'd44 - e_ff, 16'd0} - {6'd0, frac_ff};
   assign lprod_next = {33'd0, nl2} * {22'd0, TWO_LN2_Q32};
   assign l_val      = 23'((lprod_ff + 55'h80000000) >> 32);

   // Shared square root step: two radicand bits per cycle.
   assign sq_rem_n     = {sq_rem_ff, sq_x_ff[63:62]};
   assign sq_trial     = {3'd0, sq_root_ff, 2'b01};
   assign sq_ge        = sq_rem_n >= sq_trial;
   assign sq_rem_next  = sq_ge ? 35'(sq_rem_n - sq_trial) : 35'(sq_rem_n);
   assign sq_root_next = {sq_root_ff[30:0], sq_ge};

   // Divider for the polar scale: one quotient bit per cycle.
   assign v_cur        = div_second_ff ? v2_ff : v1_ff;
   assign v_abs        = v_cur[23] ? 24'(-v_cur) : 24'(v_cur);
   assign dprod_next   = {20'd0, v_abs[22:0]} * {23'd0, s_ff};
   assign dividend     = {1'b0, dprod_ff, 10'd0} + {23'd0, q_ff[31:1]};
   assign div_rem_n    = {div_rem_ff, div_q_ff[23]};
   assign div_ge       = div_rem_n >= {1'b0, q_ff};
   assign div_rem_next = div_ge ? 32'(div_rem_n - {1'b0, q_ff}) : div_rem_n[31:0];
   assign div_q_next   = {div_q_ff[22:0], div_ge};
   assign z_next       = v_cur[23] ? -$signed({1'b0, div_q_next})
                                   : $signed({1'b0, div_q_next});

   // Scaling of the unit normal by the plane deviation.
   assign sprod_next  = z_ff * $signed({1'b0, sd_ff});
   assign sample_next = 32'(rnd_shift(51'(sprod_ff), 12));

   // Shared blend multipliers for the horizontal and vertical filters.
   assign wh          = hcorr_ff[16] ? 17'h10000 : hcorr_ff;
   assign wv          = vcorr_ff[16] ? 17'h10000 : vcorr_ff;
   assign blend_h     = (state_ff == ST_HB1) || (state_ff == ST_HB2);
   assign bl_w        = blend_h ? wh : wv;
   assign bl_wc       = 17'h10000 - bl_w;
   assign bl_a        = blend_h ? prev_ff : ls_rd_ff;
   assign prod_a      = bl_a * $signed({1'b0, bl_w});
   assign prod_b      = cur_ff * $signed({1'b0, bl_wc});
   assign blend_round = 32'(rnd_shift(acc_ff, 16));

   // Output rounding, shift and saturation.
   assign sh_eff      = (shift_ff > 4'd8) ? 4'd8 : shift_ff;
   assign out_round   = 17'(rnd_shift(51'(vres_ff), 16));
   assign out_shifted = 25'(out_round) <<< sh_eff;

   always_comb begin
      if (sh_eff == 4'd0) begin
         sat_lo = -25'sd128;
         sat_hi = 25'sd127;
      end else begin
         sat_lo = -25'sd32768;
         sat_hi = 25'sd32767;
      end
      priority if (out_shifted < sat_lo) begin
         noise_next = NOISE_W'(sat_lo);
      end else if (out_shifted > sat_hi) begin
         noise_next = NOISE_W'(sat_hi);
      end else begin
         noise_next = NOISE_W'(out_shifted);
      end
   end

   // Handshake outputs.
   assign req_if.ready       = (state_ff == ST_IDLE);
   assign rsp_if.valid       = out_valid_ff;
   assign rsp_if.noise_value = out_noise_ff;

   // Sequencer: next state, datapath loads and register writes.
   always_comb begin
      state_in       = state_ff;
      job_in         = job_ff;
      sqsel_in       = sqsel_ff;
      draw_second_in = draw_second_ff;
      div_second_in  = div_second_ff;
      cnt_in         = cnt_ff;
      spare_valid_in = spare_valid_ff;
      rng_in         = rng_ff;
      luma_var_in    = luma_var_ff;
      chroma_var_in  = chroma_var_ff;
      hcorr_in       = hcorr_ff;
      vcorr_in       = vcorr_ff;
      shift_in       = shift_ff;
      spare_in       = spare_ff;
      prev_in        = prev_ff;
      col_in         = col_ff;
      chroma_in      = chroma_ff;
      lcg_lo_in      = lcg_lo_ff;
      v1_in          = v1_ff;
      v2_in          = v2_ff;
      r_in           = r_ff;
      norm_in        = norm_ff;
      e_in           = e_ff;
      y_in           = y_ff;
      frac_in        = frac_ff;
      lprod_in       = lprod_ff;
      sq_x_in        = sq_x_ff;
      sq_rem_in      = sq_rem_ff;
      sq_root_in     = sq_root_ff;
      sd_in          = sd_ff;
      s_in           = s_ff;
      q_in           = q_ff;
      dprod_in       = dprod_ff;
      div_rem_in     = div_rem_ff;
      div_q_in       = div_q_ff;
      z_in           = z_ff;
      sprod_in       = sprod_ff;
      sample_in      = sample_ff;
      cur_in         = cur_ff;
      acc_in         = acc_ff;
      vres_in        = vres_ff;
      out_noise_in   = out_noise_ff;
      mem_we         = 1'b0;
      mem_re         = 1'b0;
      mem_wd         = blend_round;
      out_load       = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_if.valid) begin
               col_in    = LS_AW'(32'(req_if.column));
               chroma_in = req_if.chroma;
               if (!req_if.mode) begin
                  job_in = JOB_PRIME;
               end else if (req_if.row_start) begin
                  job_in = JOB_ROW;
               end else begin
                  job_in = JOB_CUR;
               end
               state_in = ST_SAMPLE;
            end
         end
         // A zero variance gives a zero sample without touching the generator.
         ST_SAMPLE: begin
            if (var_sel == 16'd0) begin
               sample_in = '0;
               state_in  = ST_DISPATCH;
            end else begin
               sq_x_in    = {32'd0, var_sel, 16'd0};
               sq_rem_in  = '0;
               sq_root_in = '0;
               cnt_in     = '0;
               sqsel_in   = SQ_SD;
               state_in   = ST_SQRT;
            end
         end
         ST_SQRT: begin
            sq_x_in    = sq_x_ff << 2;
            sq_rem_in  = sq_rem_next;
            sq_root_in = sq_root_next;
            cnt_in     = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               unique case (sqsel_ff)
                  SQ_SD: begin
                     sd_in    = sq_root_next[15:0];
                     state_in = ST_NSTART;
                  end
                  SQ_S: begin
                     s_in       = sq_root_next[19:0];
                     sq_x_in    = {r_ff[43:0], 20'd0};
                     sq_rem_in  = '0;
                     sq_root_in = '0;
                     cnt_in     = '0;
                     sqsel_in   = SQ_Q;
                  end
                  SQ_Q: begin
                     q_in          = sq_root_next;
                     div_second_in = 1'b0;
                     state_in      = ST_DMUL;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         // Use the cached spare if there is one, else draw a new pair.
         ST_NSTART: begin
            if (spare_valid_ff) begin
               z_in           = spare_ff;
               spare_valid_in = 1'b0;
               state_in       = ST_SCALE;
            end else begin
               draw_second_in = 1'b0;
               state_in       = ST_LCG_A;
            end
         end
         ST_LCG_A: begin
            lcg_lo_in = lcg_lo_next;
            state_in  = ST_LCG_B;
         end
         ST_LCG_B: begin
            rng_in = rng_step;
            if (!draw_second_ff) begin
               v1_in          = v_step;
               draw_second_in = 1'b1;
               state_in       = ST_LCG_A;
            end else begin
               v2_in    = v_step;
               state_in = ST_SQ1;
            end
         end
         ST_SQ1: begin
            r_in     = 46'(v1_sq);
            state_in = ST_SQ2;
         end
         ST_SQ2: begin
            r_in     = r_ff + 46'(v2_sq);
            state_in = ST_CHECK;
         end
         // Reject pairs outside the unit circle or at the origin.
         ST_CHECK: begin
            if ((r_ff[45:44] != 2'd0) || (r_ff == 46'd0)) begin
               draw_second_in = 1'b0;
               state_in       = ST_LCG_A;
            end else begin
               norm_in  = r_ff[43:0];
               e_in     = 6'd43;
               state_in = ST_NORM;
            end
         end
         // Normalize the radius, a byte or a bit per cycle.
         ST_NORM: begin
            priority if (norm_ff[43]) begin
               y_in     = norm_ff[43:13];
               frac_in  = '0;
               cnt_in   = '0;
               state_in = ST_LOG;
            end else if (norm_ff[43:36] == 8'd0) begin
               norm_in = norm_ff << 8;
               e_in    = e_ff - 6'd8;
            end else begin
               norm_in = norm_ff << 1;
               e_in    = e_ff - 6'd1;
            end
         end
         ST_LOG: begin
            frac_in = {frac_ff[14:0], ysh[31]};
            y_in    = ysh[31] ? ysh[31:1] : ysh[30:0];
            cnt_in  = cnt_ff + 5'd1;
            if (cnt_ff == 5'd15) begin
               state_in = ST_LMUL;
            end
         end
         ST_LMUL: begin
            lprod_in = lprod_next;
            state_in = ST_LSQRT;
         end
         ST_LSQRT: begin
            sq_x_in    = {25'd0, l_val, 16'd0};
            sq_rem_in  = '0;
            sq_root_in = '0;
            cnt_in     = '0;
            sqsel_in   = SQ_S;
            state_in   = ST_SQRT;
         end
         ST_DMUL: begin
            dprod_in = dprod_next;
            state_in = ST_DLOAD;
         end
         ST_DLOAD: begin
            div_rem_in = {2'd0, dividend[53:24]};
            div_q_in   = dividend[23:0];
            cnt_in     = '0;
            state_in   = ST_DIV;
         end
         // The first quotient becomes the spare, the second the sample.
         ST_DIV: begin
            div_rem_in = div_rem_next;
            div_q_in   = div_q_next;
            cnt_in     = cnt_ff + 5'd1;
            if (cnt_ff == 5'd23) begin
               if (!div_second_ff) begin
                  spare_in       = z_next;
                  spare_valid_in = 1'b1;
                  div_second_in  = 1'b1;
                  state_in       = ST_DMUL;
               end else begin
                  z_in     = z_next;
                  state_in = ST_SCALE;
               end
            end
         end
         ST_SCALE: begin
            sprod_in = sprod_next;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            sample_in = sample_next;
            state_in  = ST_DISPATCH;
         end
         ST_DISPATCH: begin
            unique case (job_ff)
               JOB_PRIME: begin
                  mem_we   = 1'b1;
                  mem_wd   = sample_ff;
                  state_in = ST_IDLE;
               end
               JOB_ROW: begin
                  prev_in  = sample_ff;
                  job_in   = JOB_CUR;
                  state_in = ST_SAMPLE;
               end
               JOB_CUR: begin
                  cur_in   = sample_ff;
                  state_in = ST_HB1;
               end
               default: state_in = ST_IDLE;
            endcase
         end
         // Horizontal filter; the line store read goes out meanwhile.
         ST_HB1: begin
            acc_in   = 51'(prod_a);
            state_in = ST_HB2;
         end
         ST_HB2: begin
            acc_in   = acc_ff + 51'(prod_b);
            mem_re   = 1'b1;
            state_in = ST_HB3;
         end
         ST_HB3: begin
            prev_in  = blend_round;
            cur_in   = blend_round;
            state_in = ST_VB1;
         end
         // Vertical filter against the stored column.
         ST_VB1: begin
            acc_in   = 51'(prod_a);
            state_in = ST_VB2;
         end
         ST_VB2: begin
            acc_in   = acc_ff + 51'(prod_b);
            state_in = ST_VB3;
         end
         ST_VB3: begin
            vres_in  = blend_round;
            mem_we   = 1'b1;
            state_in = ST_OUT;
         end
         // Hand the result to the output register once it is free.
         ST_OUT: begin
            if (!out_valid_ff || rsp_if.ready) begin
               out_load     = 1'b1;
               out_noise_in = noise_next;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // Output register: cleared when taken, set on load.
      out_valid_in = out_valid_ff && !rsp_if.ready;
      if (out_load) begin
         out_valid_in = 1'b1;
      end

      // Register writes must arrive only while the block is idle; the block does not enforce it.
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_SEED: begin
               rng_in         = csr_wdata;
               spare_valid_in = 1'b0;
            end
            CSR_LUMA:   luma_var_in   = csr_wdata[15:0];
            CSR_CHROMA: chroma_var_in = csr_wdata[15:0];
            CSR_HCORR:  hcorr_in      = csr_wdata[16:0];
            CSR_VCORR:  vcorr_in      = csr_wdata[16:0];
            CSR_SCALE:  shift_in      = csr_wdata[3:0];
            default: begin
            end
         endcase
      end
   end

   // Control, configuration and generator state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         spare_valid_ff <= 1'b0;
         out_valid_ff   <= 1'b0;
         rng_ff         <= 64'd1;
         luma_var_ff    <= 16'd256;
         chroma_var_ff  <= '0;
         hcorr_ff       <= '0;
         vcorr_ff       <= '0;
         shift_ff       <= '0;
         spare_ff       <= '0;
         prev_ff        <= '0;
      end else begin
         state_ff       <= state_in;
         spare_valid_ff <= spare_valid_in;
         out_valid_ff   <= out_valid_in;
         rng_ff         <= rng_in;
         luma_var_ff    <= luma_var_in;
         chroma_var_ff  <= chroma_var_in;
         hcorr_ff       <= hcorr_in;
         vcorr_ff       <= vcorr_in;
         shift_ff       <= shift_in;
         spare_ff       <= spare_in;
         prev_ff        <= prev_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      job_ff         <= job_in;
      sqsel_ff       <= sqsel_in;
      draw_second_ff <= draw_second_in;
      div_second_ff  <= div_second_in;
      cnt_ff         <= cnt_in;
      col_ff         <= col_in;
      chroma_ff      <= chroma_in;
      lcg_lo_ff      <= lcg_lo_in;
      v1_ff          <= v1_in;
      v2_ff          <= v2_in;
      r_ff           <= r_in;
      norm_ff        <= norm_in;
      e_ff           <= e_in;
      y_ff           <= y_in;
      frac_ff        <= frac_in;
      lprod_ff       <= lprod_in;
      sq_x_ff        <= sq_x_in;
      sq_rem_ff      <= sq_rem_in;
      sq_root_ff     <= sq_root_in;
      sd_ff          <= sd_in;
      s_ff           <= s_in;
      q_ff           <= q_in;
      dprod_ff       <= dprod_in;
      div_rem_ff     <= div_rem_in;
      div_q_ff       <= div_q_in;
      z_ff           <= z_in;
      sprod_ff       <= sprod_in;
      sample_ff      <= sample_in;
      cur_ff         <= cur_in;
      acc_ff         <= acc_in;
      vres_ff        <= vres_in;
      out_noise_ff   <= out_noise_in;
   end

   // Line store memory with a registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         ls_mem[col_ff] <= mem_wd;
      end
      if (mem_re) begin
         ls_rd_ff <= ls_mem[col_ff];
      end
   end

`ifndef NO_ASSERTIONS
   // The spare is cached only as the first division of a pair finishes.
   assert property (@(posedge clock) disable iff (reset)
      $rose(spare_valid_ff) |-> $past(state_ff == ST_DIV))
      else $error("spare cached outside the divider");

   // The line store is written only by a prime or at the end of the vertical filter.
   assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == ST_DISPATCH || state_ff == ST_VB3))
      else $error("line store written in an unexpected state");

   // A waiting result is never overwritten.
   assert property (@(posedge clock) disable iff (reset)
      out_load |-> (!out_valid_ff || rsp_if.ready))
      else $error("output register overwritten");

   // The logarithm operand stays normalized to [1, 2).
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOG) |-> y_ff[30])
      else $error("logarithm operand lost normalization");

   // The divider remainder stays below the divisor.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (div_rem_ff < q_ff))
      else $error("divider remainder out of range");
`endif

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps
// Testbench for correlated_gaussian_grain_generator: drives prime and sample items,
// predicts every noise value with a built-in fixed-point model and checks it.
// Depends on cggg_pkg, cggg_req_if, cggg_rsp_if and the generator RTL.
module tb;
   import cggg_pkg::*;

   localparam bit MODE_PRIME  = 1'b0;
   localparam bit MODE_SAMPLE = 1'b1;

   // Prediction of the grain generator and the queue of noise values it owes.
   class grain_scoreboard;
      longint unsigned rng;
      int unsigned     luma_var, chroma_var, hcorr, vcorr, shift;
      bit              spare_ok;
      int              spare, prev;
      int              line_val[LINE_WIDTH];
      bit              written[LINE_WIDTH];
      int unsigned     primed_cols[$];
      logic signed [NOISE_W-1:0] noise_q[$];
      int              errors;

      function void init();
         rng = 64'd1;
         luma_var = 256;
         chroma_var = 0;
         hcorr = 0;
         vcorr = 0;
         shift = 0;
         spare_ok = 0;
         spare = 0;
         prev = 0;
         errors = 0;
      endfunction

      function void set_reg(csr_index_type idx, logic [63:0] val);
         case (idx)
            CSR_SEED: begin
               rng = val;
               spare_ok = 0;
            end
            CSR_LUMA:   luma_var = val[15:0];
            CSR_CHROMA: chroma_var = val[15:0];
            CSR_HCORR:  hcorr = val[16:0];
            CSR_VCORR:  vcorr = val[16:0];
            CSR_SCALE:  shift = val[3:0];
            default: ;
         endcase
      endfunction

      function longint unsigned isqrt(longint unsigned x);
         longint unsigned res = 0;
         longint unsigned b = 64'h1 << 62;
         while (b > x) b >>= 2;
         while (b != 0) begin
            if (x >= res + b) begin
               x -= res + b;
               res = (res >> 1) + b;
            end else begin
               res >>= 1;
            end
            b >>= 2;
         end
         return res;
      endfunction

      // Shift right with rounding half away from zero.
      function longint round_shift(longint x, int n);
         longint unsigned m;
         m = (x < 0) ? longint'(-x) : x;
         m = (m + (64'd1 << (n - 1))) >> n;
         return (x < 0) ? -longint'(m) : longint'(m);
      endfunction

      // One LCG step; the low 23 bits become v in Q.22.
      function longint draw_v();
         rng = rng * 64'd1664525 + 64'd1013904223;
         return longint'({41'd0, rng[22:0]}) - 64'sd4194304;
      endfunction

      function int polar_scale(longint v, longint unsigned s, longint unsigned q);
         longint unsigned mag, z;
         mag = (v < 0) ? longint'(-v) : v;
         z = (mag * s * 1024 + q / 2) / q;
         return (v < 0) ? -int'(z) : int'(z);
      endfunction

      function int unit_normal();
         longint          v1, v2;
         longint unsigned r, y, nl2, l, s, q;
         int unsigned     e, frac;
         if (spare_ok) begin
            spare_ok = 0;
            return spare;
         end
         do begin
            v1 = draw_v();
            v2 = draw_v();
            r = longint'(v1 * v1) + longint'(v2 * v2);
         end while (r >= (64'd1 << 44) || r == 0);
         e = 0;
         frac = 0;
         while ((r >> (e + 1)) != 0) e++;
         y = (e <= 30) ? (r << (30 - e)) : (r >> (e - 30));
         for (int i = 0; i < 16; i++) begin
            y = (y * y) >> 30;
            frac <<= 1;
            if (y >= (64'd1 << 31)) begin
               frac |= 1;
               y >>= 1;
            end
         end
         nl2 = 64'd44 * 65536 - (longint'(e) * 65536 + frac);
         l = (nl2 * 64'd5954088944 + (64'd1 << 31)) >> 32;
         s = isqrt(l << 16);
         q = isqrt(r << 20);
         spare = polar_scale(v1, s, q);
         spare_ok = 1;
         return polar_scale(v2, s, q);
      endfunction

      function int plane_sample(bit ch);
         int unsigned     var_q;
         longint unsigned sd;
         var_q = ch ? chroma_var : luma_var;
         if (var_q == 0) return 0;
         sd = isqrt(longint'(var_q) << 16);
         return int'(round_shift(longint'(unit_normal()) * longint'(sd), 12));
      endfunction

      function int blend(int p, int c, int unsigned w);
         if (w > 65536) w = 65536;
         return int'(round_shift(longint'(p) * longint'(w) + longint'(c) * longint'(65536 - w),
                                 16));
      endfunction

      // Called once per accepted request transaction.
      function void note_item(bit mode, logic [COLUMN_W-1:0] col, bit row, bit ch);
         int     h, c, v, sh;
         longint n;
         if (mode == MODE_PRIME) begin
            line_val[col] = plane_sample(ch);
            if (!written[col]) primed_cols.push_back(col);
            written[col] = 1;
            return;
         end
         if (row) prev = plane_sample(ch);
         c = plane_sample(ch);
         h = blend(prev, c, hcorr);
         prev = h;
         v = blend(line_val[col], h, vcorr);
         line_val[col] = v;
         sh = (shift > 8) ? 8 : shift;
         n = round_shift(v, 16) * (64'sd1 << sh);
         if (sh == 0) begin
            if (n < -128) n = -128;
            if (n > 127) n = 127;
         end else begin
            if (n < -32768) n = -32768;
            if (n > 32767) n = 32767;
         end
         noise_q.push_back(n[NOISE_W-1:0]);
      endfunction

      // Called once per accepted response transaction.
      function void check_noise(logic signed [NOISE_W-1:0] got);
         logic signed [NOISE_W-1:0] want;
         if (noise_q.size() == 0) begin
            $error("noise_value: no result expected, got %0d", got);
            errors++;
            return;
         end
         want = noise_q.pop_front();
         if (got !== want) begin
            $error("noise_value: expected %0d, got %0d", want, got);
            errors++;
         end
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;
   int                     send_idle, recv_idle, hold_left;
   grain_scoreboard        sb;

   cggg_req_if req_if ();
   cggg_rsp_if rsp_if ();

   correlated_gaussian_grain_generator uut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .rsp_if    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #6 clock = ~clock;

   // Receiver: random stalls plus one long hold-off.
   always @(posedge clock) begin
      if (hold_left > 0) hold_left--;
      rsp_if.ready <= !reset && hold_left == 0 && $urandom_range(99) >= recv_idle;
   end

   // Handshake values are settled at the falling edge; the transaction completes next edge.
   always @(negedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) sb.check_noise(rsp_if.noise_value);
   end

   // Sends one item; called just after a rising edge and returns at the accepting edge.
   task automatic send_item(bit mode, logic [COLUMN_W-1:0] col, bit row, bit ch);
      while ($urandom_range(99) < send_idle) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.mode      <= mode;
      req_if.column    <= col;
      req_if.row_start <= row;
      req_if.chroma    <= ch;
      @(negedge clock);
      while (!req_if.ready) @(negedge clock);
      @(posedge clock);
      sb.note_item(mode, col, row, ch);
   endtask

   // Lets all owed results drain, then waits out any result-free item still in work.
   task automatic drain();
      req_if.valid <= 1'b0;
      while (sb.noise_q.size() != 0) @(posedge clock);
      repeat (2000) @(posedge clock);
   endtask

   // Writes all six registers back to back; the block must be idle.
   task automatic write_regs(logic [63:0] seed, logic [15:0] luma, logic [15:0] chroma,
                             logic [16:0] hc, logic [16:0] vc, logic [3:0] sc);
      csr_index_type idx;
      logic [63:0]   vals[6];
      vals = '{seed, luma, chroma, hc, vc, sc};
      for (int i = 0; i < 6; i++) begin
         idx = csr_index_type'(i);
         csr_we    <= 1'b1;
         csr_index <= idx;
         csr_wdata <= vals[i];
         @(posedge clock);
         sb.set_reg(idx, vals[i]);
      end
      csr_we <= 1'b0;
   endtask

   function automatic logic [16:0] pick_corr();
      case ($urandom_range(5))
         0: return 17'd0;
         1: return 17'd65536;
         2: return 17'h1FFFF;
         default: return 17'($urandom_range(65536));
      endcase
   endfunction

   function automatic logic [15:0] pick_var();
      case ($urandom_range(5))
         0: return 16'd0;
         1: return 16'hFFFF;
         default: return 16'($urandom_range(4096));
      endcase
   endfunction

   // Mostly samples on primed columns, with primes of small and full-range columns.
   task automatic random_item();
      logic [COLUMN_W-1:0] col;
      if (sb.primed_cols.size() == 0 || $urandom_range(99) < 20) begin
         col = ($urandom_range(1) == 1) ? COLUMN_W'($urandom_range(15))
                                        : COLUMN_W'($urandom_range(4095));
         send_item(MODE_PRIME, col, 1'($urandom_range(1)), 1'($urandom_range(1)));
      end else begin
         col = COLUMN_W'(sb.primed_cols[$urandom_range(sb.primed_cols.size() - 1)]);
         send_item(MODE_SAMPLE, col, $urandom_range(99) < 15, 1'($urandom_range(1)));
      end
   endtask

   initial begin
      sb = new();
      sb.init();
      reset            <= 1'b1;
      csr_we           <= 1'b0;
      csr_index        <= CSR_SEED;
      csr_wdata        <= '0;
      req_if.valid     <= 1'b0;
      req_if.mode      <= MODE_PRIME;
      req_if.column    <= '0;
      req_if.row_start <= 1'b0;
      req_if.chroma    <= 1'b0;
      send_idle = 27;
      recv_idle = 45;
      hold_left = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: reset settings, then field and register extremes.
      send_item(MODE_PRIME, 12'd0, 1'b0, 1'b0);
      send_item(MODE_SAMPLE, 12'd0, 1'b1, 1'b0);
      drain();
      write_regs(64'd0, 16'hFFFF, 16'd0, 17'd0, 17'd0, 4'd0);
      send_item(MODE_PRIME, 12'd4095, 1'b0, 1'b1);
      send_item(MODE_PRIME, 12'd2730, 1'b1, 1'b0);
      send_item(MODE_PRIME, 12'd1365, 1'b0, 1'b1);
      send_item(MODE_SAMPLE, 12'd0, 1'b1, 1'b0);
      send_item(MODE_SAMPLE, 12'd4095, 1'b0, 1'b1);
      send_item(MODE_SAMPLE, 12'd2730, 1'b0, 1'b0);
      send_item(MODE_SAMPLE, 12'd1365, 1'b1, 1'b1);
      drain();
      write_regs(64'hFFFF_FFFF_FFFF_FFFF, 16'd1, 16'hFFFF, 17'd65536, 17'd65536, 4'd8);
      send_item(MODE_SAMPLE, 12'd0, 1'b1, 1'b1);
      send_item(MODE_SAMPLE, 12'd4095, 1'b0, 1'b0);
      send_item(MODE_SAMPLE, 12'd2730, 1'b1, 1'b0);
      send_item(MODE_SAMPLE, 12'd1365, 1'b0, 1'b1);
      drain();
      write_regs(64'd1, 16'd256, 16'd12345, 17'h1FFFF, 17'd32768, 4'hF);
      send_item(MODE_SAMPLE, 12'd0, 1'b1, 1'b0);
      send_item(MODE_SAMPLE, 12'd2730, 1'b0, 1'b1);
      send_item(MODE_PRIME, 12'd7, 1'b0, 1'b1);
      send_item(MODE_SAMPLE, 12'd7, 1'b0, 1'b1);
      send_item(MODE_SAMPLE, 12'd4095, 1'b1, 1'b1);

      // Random phases, each under its own register setting.
      for (int p = 0; p < 12; p++) begin
         drain();
         if (p == 4) begin
            send_idle = 45;
            recv_idle = 27;
         end else if (p == 8) begin
            send_idle = 0;
            recv_idle = 0;
         end
         write_regs({$urandom, $urandom}, pick_var(), pick_var(), pick_corr(), pick_corr(),
                    4'($urandom_range(15)));
         // Long receiver hold-off so the block backs up into the request channel.
         if (p == 9) hold_left = 800;
         for (int i = 0; i < 46; i++) random_item();
      end

      drain();
      if (sb.errors == 0 && sb.noise_q.size() == 0) begin
         $display("Verification passed");
      end else begin
         if (sb.noise_q.size() != 0)
            $error("noise_value: %0d expected results never arrived", sb.noise_q.size());
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("Verification failed");
      $finish;
   end
endmodule

>>> filelist.f
rtl/core/cggg_pkg.sv
rtl/core/cggg_req_if.sv
rtl/core/cggg_rsp_if.sv
rtl/core/correlated_gaussian_grain_generator.sv
verif/tb.sv
